// File: sv/mmrc_pkg.sv
// Package for the Modbus meter reply checker: codes, frame constants,
// the job record passed between front and back, and the CRC-16 byte step.
// No dependencies.
package mmrc_pkg;

   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_BYTE    = 2'd2;
   localparam logic [1:0] OP_TIMEOUT = 2'd3;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TIMEOUT     = 3'd1;
   localparam logic [2:0] ST_CRC         = 3'd2;
   localparam logic [2:0] ST_EXCEPTION   = 3'd3;
   localparam logic [2:0] ST_BAD_HEADER  = 3'd4;
   localparam logic [2:0] ST_BAD_NEW_ADR = 3'd5;

   localparam logic       KIND_READ  = 1'b0;
   localparam logic       KIND_WRITE = 1'b1;

   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [7:0]  EXC_MASK      = 8'h80;
   localparam logic [7:0]  FN_READ_INPUT = 8'h04;
   localparam logic [7:0]  FN_WRITE_REG  = 8'h06;
   localparam logic [15:0] ADDR_REG      = 16'h0002;
   localparam logic [7:0]  MAX_UNIT_ADDR = 8'hF7;
   localparam logic [7:0]  READ_DATA_LEN = 8'd20;
   localparam logic [15:0] ALARM_ON      = 16'hFFFF;
   localparam logic [7:0]  GEN_ADDR_INIT = 8'd248;
   localparam int          READ_LEN      = 25;
   localparam int          WRITE_LEN     = 8;
   localparam int          REG_WORD_COUNT = 10;

   typedef struct packed {
      logic [2:0]                       status;
      logic                             reply_kind;
      logic [7:0]                       unit_addr;
      logic [REG_WORD_COUNT-1:0][15:0]  reg_words;
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_flags_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: sv/mmrc_front.sv
// Front part of the meter reply checker: accepts items, runs the CRC,
// stores frame bytes and classifies finished or timed-out frames into jobs.
// Depends on mmrc_pkg.
module mmrc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic [7:0]               req_requested_addr,
   input  logic [7:0]               req_new_addr,
   input  logic [7:0]               req_rx_byte,
   input  logic                     csr_write_enable,
   input  logic [7:0]               csr_write_data,
   input  mmrc_pkg::queue_flags_type queue_flags,
   output logic                     push,
   output mmrc_pkg::job_type        job
);

   localparam logic [4:0] LEN_READ  = 5'(mmrc_pkg::READ_LEN);
   localparam logic [4:0] LEN_WRITE = 5'(mmrc_pkg::WRITE_LEN);

   logic        active_ff, active_in;
   logic [4:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic        kind_ff, kind_in;
   logic [7:0]  exp_addr_ff, exp_addr_in;
   logic [7:0]  exp_new_ff, exp_new_in;
   logic [7:0]  gen_addr_ff;
   logic [7:0]  frame_ff [mmrc_pkg::READ_LEN];

   logic        accept;
   logic        frame_we;
   logic [4:0]  frame_len;
   logic        is_last;
   logic        broadcast;
   logic [15:0] crc_got;
   logic        read_addr_ok;
   logic [2:0]  check_status;

   assign req_stall = queue_flags.full;
   assign accept    = req_valid && !req_stall;
   assign frame_len = kind_ff ? LEN_WRITE : LEN_READ;
   assign is_last   = (count_ff == frame_len - 5'd1);
   assign broadcast = (exp_addr_ff == gen_addr_ff);
   assign crc_got   = {req_rx_byte, kind_ff ? frame_ff[mmrc_pkg::WRITE_LEN-2]
                                            : frame_ff[mmrc_pkg::READ_LEN-2]};
   assign read_addr_ok = broadcast ? (frame_ff[0] != 8'd0 && frame_ff[0] <= gen_addr_ff)
                                   : (frame_ff[0] == exp_addr_ff);

   always_comb begin
      if (crc_got != crc_ff) begin
         check_status = mmrc_pkg::ST_CRC;
      end else if ((frame_ff[1] & mmrc_pkg::EXC_MASK) != 8'd0) begin
         check_status = mmrc_pkg::ST_EXCEPTION;
      end else if (kind_ff == mmrc_pkg::KIND_READ) begin
         if (!read_addr_ok || frame_ff[1] != mmrc_pkg::FN_READ_INPUT
             || frame_ff[2] != mmrc_pkg::READ_DATA_LEN) begin
            check_status = mmrc_pkg::ST_BAD_HEADER;
         end else begin
            check_status = mmrc_pkg::ST_OK;
         end
      end else if (!(broadcast || frame_ff[0] == exp_addr_ff)
                   || frame_ff[1] != mmrc_pkg::FN_WRITE_REG
                   || frame_ff[2] != mmrc_pkg::ADDR_REG[15:8]
                   || frame_ff[3] != mmrc_pkg::ADDR_REG[7:0]
                   || frame_ff[4] != 8'd0
                   || frame_ff[5] != exp_new_ff) begin
         check_status = mmrc_pkg::ST_BAD_HEADER;
      end else if (exp_new_ff == 8'd0 || exp_new_ff > mmrc_pkg::MAX_UNIT_ADDR) begin
         check_status = mmrc_pkg::ST_BAD_NEW_ADR;
      end else begin
         check_status = mmrc_pkg::ST_OK;
      end
   end

   always_comb begin
      job.reply_kind = kind_ff;
      for (int n = 0; n < mmrc_pkg::REG_WORD_COUNT; n++) begin
         job.reg_words[n] = {frame_ff[3 + 2*n], frame_ff[4 + 2*n]};
      end
      if (req_op == mmrc_pkg::OP_TIMEOUT) begin
         job.status    = mmrc_pkg::ST_TIMEOUT;
         job.unit_addr = (count_ff != 5'd0) ? frame_ff[0] : 8'd0;
      end else begin
         job.status    = check_status;
         job.unit_addr = frame_ff[0];
      end
   end

   always_comb begin
      active_in   = active_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      kind_in     = kind_ff;
      exp_addr_in = exp_addr_ff;
      exp_new_in  = exp_new_ff;
      frame_we    = 1'b0;
      push        = 1'b0;
      if (accept) begin
         unique case (req_op) inside
            mmrc_pkg::OP_READ, mmrc_pkg::OP_WRITE: begin
               kind_in     = (req_op == mmrc_pkg::OP_WRITE) ? mmrc_pkg::KIND_WRITE
                                                            : mmrc_pkg::KIND_READ;
               exp_addr_in = req_requested_addr;
               exp_new_in  = (req_op == mmrc_pkg::OP_WRITE) ? req_new_addr : 8'd0;
               count_in    = 5'd0;
               crc_in      = mmrc_pkg::CRC_INIT;
               active_in   = 1'b1;
            end
            mmrc_pkg::OP_BYTE: begin
               if (active_ff) begin
                  if (count_ff >= frame_len) begin
                     active_in = 1'b0;
                  end else begin
                     frame_we = 1'b1;
                     if (count_ff < frame_len - 5'd2) begin
                        crc_in = mmrc_pkg::crc16_byte(crc_ff, req_rx_byte);
                     end
                     count_in = count_ff + 5'd1;
                     if (is_last) begin
                        active_in = 1'b0;
                        push      = 1'b1;
                     end
                  end
               end
            end
            mmrc_pkg::OP_TIMEOUT: begin
               if (active_ff) begin
                  active_in = 1'b0;
                  push      = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         count_ff    <= 5'd0;
         crc_ff      <= mmrc_pkg::CRC_INIT;
         kind_ff     <= mmrc_pkg::KIND_READ;
         exp_addr_ff <= 8'd0;
         exp_new_ff  <= 8'd0;
         gen_addr_ff <= mmrc_pkg::GEN_ADDR_INIT;
      end else begin
         active_ff   <= active_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         kind_ff     <= kind_in;
         exp_addr_ff <= exp_addr_in;
         exp_new_ff  <= exp_new_in;
         if (csr_write_enable) begin
            gen_addr_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_ff[count_ff] <= req_rx_byte;
      end
   end

endmodule

// File: sv/mmrc_queue.sv
// Short job queue between the front and back parts of the reply checker.
// Depends on mmrc_pkg.
module mmrc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mmrc_pkg::job_type         push_job,
   input  logic                      pop,
   output mmrc_pkg::job_type         head_job,
   output mmrc_pkg::queue_flags_type flags
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mmrc_pkg::job_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign flags.full      = (count_ff == FULL_CNT);
   assign flags.not_empty = (count_ff != '0);
   assign do_push  = push && !flags.full;
   assign do_pop   = pop && flags.not_empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/mmrc_back.sv
// Back part of the reply checker: takes jobs from the queue, builds the
// readings and holds them in the output register. Depends on mmrc_pkg.
module mmrc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mmrc_pkg::job_type         head_job,
   input  mmrc_pkg::queue_flags_type queue_flags,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_status,
   output logic                      rsp_reply_kind,
   output logic [7:0]                rsp_unit_addr,
   output logic [15:0]               rsp_voltage_raw,
   output logic [31:0]               rsp_current_raw,
   output logic [31:0]               rsp_active_power,
   output logic [31:0]               rsp_energy_total,
   output logic [15:0]               rsp_frequency_raw,
   output logic [15:0]               rsp_pf_reading,
   output logic                      rsp_alarm
);

   logic        valid_ff;
   logic [2:0]  status_ff;
   logic        kind_ff;
   logic [7:0]  unit_ff;
   logic [15:0] voltage_ff, frequency_ff, pf_ff;
   logic [31:0] current_ff, power_ff, energy_ff;
   logic        alarm_ff;
   logic        good_read;

   assign pop = queue_flags.not_empty && (!valid_ff || !rsp_stall);
   assign good_read = (head_job.status == mmrc_pkg::ST_OK)
                      && (head_job.reply_kind == mmrc_pkg::KIND_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= head_job.status;
         kind_ff   <= head_job.reply_kind;
         unit_ff   <= head_job.unit_addr;
         if (good_read) begin
            voltage_ff   <= head_job.reg_words[0];
            current_ff   <= {head_job.reg_words[2], head_job.reg_words[1]};
            power_ff     <= {head_job.reg_words[4], head_job.reg_words[3]};
            energy_ff    <= {head_job.reg_words[6], head_job.reg_words[5]};
            frequency_ff <= head_job.reg_words[7];
            pf_ff        <= head_job.reg_words[8];
            alarm_ff     <= (head_job.reg_words[9] == mmrc_pkg::ALARM_ON);
         end else begin
            voltage_ff   <= 16'd0;
            current_ff   <= 32'd0;
            power_ff     <= 32'd0;
            energy_ff    <= 32'd0;
            frequency_ff <= 16'd0;
            pf_ff        <= 16'd0;
            alarm_ff     <= 1'b0;
         end
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_reply_kind    = kind_ff;
   assign rsp_unit_addr     = unit_ff;
   assign rsp_voltage_raw   = voltage_ff;
   assign rsp_current_raw   = current_ff;
   assign rsp_active_power  = power_ff;
   assign rsp_energy_total  = energy_ff;
   assign rsp_frequency_raw = frequency_ff;
   assign rsp_pf_reading    = pf_ff;
   assign rsp_alarm         = alarm_ff;

endmodule

// File: sv/modbus_meter_response_checker_unit.sv
// rsp_valid rises once the item completing or timing out a frame has been written to the
// job queue and then loaded into the output register; a stall on rsp_stall can hold it back.
// Throughput: one item per cycle while the job queue is not full; the CRC byte step and the
// frame checks are combinational in the front part. The input stalls only while the job queue is full.
// Reset is synchronous and active high; it idles the block and empties the queue.
// Top level; depends on mmrc_pkg, mmrc_front, mmrc_queue and mmrc_back.
module modbus_meter_response_checker_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_requested_addr,
   input  logic [7:0]  req_new_addr,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_reply_kind,
   output logic [7:0]  rsp_unit_addr,
   output logic [15:0] rsp_voltage_raw,
   output logic [31:0] rsp_current_raw,
   output logic [31:0] rsp_active_power,
   output logic [31:0] rsp_energy_total,
   output logic [15:0] rsp_frequency_raw,
   output logic [15:0] rsp_pf_reading,
   output logic        rsp_alarm,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   mmrc_pkg::job_type         push_job;
   mmrc_pkg::job_type         head_job;
   mmrc_pkg::queue_flags_type queue_flags;
   logic                      push;
   logic                      pop;

   mmrc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_requested_addr (req_requested_addr),
      .req_new_addr       (req_new_addr),
      .req_rx_byte        (req_rx_byte),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .queue_flags        (queue_flags),
      .push               (push),
      .job                (push_job)
   );

   mmrc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .flags    (queue_flags)
   );

   mmrc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_job          (head_job),
      .queue_flags       (queue_flags),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_reply_kind    (rsp_reply_kind),
      .rsp_unit_addr     (rsp_unit_addr),
      .rsp_voltage_raw   (rsp_voltage_raw),
      .rsp_current_raw   (rsp_current_raw),
      .rsp_active_power  (rsp_active_power),
      .rsp_energy_total  (rsp_energy_total),
      .rsp_frequency_raw (rsp_frequency_raw),
      .rsp_pf_reading    (rsp_pf_reading),
      .rsp_alarm         (rsp_alarm)
   );

endmodule

// File: sv/mmrc_checker.sv
// Port-level checks for the meter reply checker, bound to the top level.
// Depends on mmrc_pkg and modbus_meter_response_checker_unit.
module mmrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic        rsp_reply_kind,
   input logic [15:0] rsp_voltage_raw,
   input logic [31:0] rsp_current_raw,
   input logic [31:0] rsp_active_power,
   input logic [31:0] rsp_energy_total,
   input logic [15:0] rsp_frequency_raw,
   input logic [15:0] rsp_pf_reading,
   input logic        rsp_alarm
);

   a_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Stalled item was dropped.");

   a_zero_readings : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != mmrc_pkg::ST_OK || rsp_reply_kind == mmrc_pkg::KIND_WRITE)
      |-> rsp_voltage_raw == 16'd0 && rsp_current_raw == 32'd0 && rsp_active_power == 32'd0
          && rsp_energy_total == 32'd0 && rsp_frequency_raw == 16'd0
          && rsp_pf_reading == 16'd0 && !rsp_alarm)
      else $error("Readings are not zero on a failed or write reply.");

   a_new_addr_write : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mmrc_pkg::ST_BAD_NEW_ADR
      |-> rsp_reply_kind == mmrc_pkg::KIND_WRITE)
      else $error("New address status on a read reply.");

   a_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result shown right after reset.");

endmodule

bind modbus_meter_response_checker_unit mmrc_checker u_mmrc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_reply_kind    (rsp_reply_kind),
   .rsp_voltage_raw   (rsp_voltage_raw),
   .rsp_current_raw   (rsp_current_raw),
   .rsp_active_power  (rsp_active_power),
   .rsp_energy_total  (rsp_energy_total),
   .rsp_frequency_raw (rsp_frequency_raw),
   .rsp_pf_reading    (rsp_pf_reading),
   .rsp_alarm         (rsp_alarm)
);
